// ===== sv/psa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and constants of the paged bitmap slot allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam int ADDR_W     = 15;
    localparam int FUNC_W     = 2;
    localparam int ST_W       = 2;
    localparam int OBJ_W      = 11;
    localparam int SPP_W      = 8;
    localparam int OFF_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int PAGE_BYTES = 2048;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PG_FIELD_W = ADDR_W - PAGE_SHIFT;

    localparam int WORD_W = 32;
    localparam int BIT_W  = $clog2(WORD_W);

    localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE    = 2'd1;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_PAGE  = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_FREE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_PAGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STORAGE_OFFSET = 2'd2;

    localparam logic [OBJ_W-1:0] OBJ_SIZE_RST = 11'd8;
    localparam logic [SPP_W-1:0] SPP_RST      = 8'd248;
    localparam logic [OFF_W-1:0] SOFF_RST     = 11'd56;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_OPEN,
        S_CALC,
        S_FREE_RD,
        S_FREE_WR,
        S_OUT
    } t_state;

    typedef enum logic {
        MD_MUL,
        MD_DIV
    } t_md_op;

    typedef struct packed {
        logic   start;
        t_md_op op;
    } t_md_req;

endpackage

// ===== sv/paged_bitmap_slot_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_bitmap_slot_allocator_core
// Fixed-size object allocator over a pool of pages with used-slot bitmaps.
// ----------------------------------------------------------------------------
// Requests enter on i_in_valid/o_in_stall with i_func and i_address; each
// request gives exactly one result on o_out_valid/i_out_stall with o_status
// and o_result_address. Registers are written through i_cfg_wr_en with
// i_cfg_index and i_cfg_wr_data; the user must write them only while no
// request is in flight; the block does not enforce this. One request is
// handled at a time; o_in_stall is high from acceptance until the result
// moves into the output register. The bitmaps live in one RAM of 32-bit
// words, read and written through one port pair; the scan reads each word
// in S_SCAN_RD and checks it in S_SCAN_CHK. Allocate scans up to 8 words a
// page, pages from the newest open one down; S_OPEN clears a new page's
// words in turn. The serial multiplier, OPW = max(slot index bits, 11)
// bits wide, then forms the address. Free runs the serial divider, then
// reads and writes the bitmap word. Release and unused codes go to S_OUT
// directly. A stalled receiver holds the result in the output register; a
// further request is still accepted; its result waits in S_OUT meanwhile.
// Reset closes all pages and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module paged_bitmap_slot_allocator_core import psa_pkg::*; #(
    parameter int NUM_PAGES = 16,
    parameter int MAX_SLOTS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [ADDR_W-1:0]     i_address,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ST_W-1:0]       o_status,
    output logic [ADDR_W-1:0]     o_result_address,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data
);

    localparam int PW   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int OPG  = $clog2(NUM_PAGES + 1);
    localparam int WPP  = (MAX_SLOTS + WORD_W - 1) / WORD_W;
    localparam int WIW  = (WPP > 1) ? $clog2(WPP) : 1;
    localparam int SLW  = WIW + BIT_W;
    localparam int CW   = (SLW > SPP_W) ? SLW : SPP_W;
    localparam int OPW  = (SLW > OFF_W) ? SLW : OFF_W;
    localparam int PCW  = (PG_FIELD_W > OPG) ? PG_FIELD_W : OPG;
    localparam int PEW  = PG_FIELD_W + PW;
    localparam int OEW  = OPG + PW;
    localparam int AEW  = PW + PG_FIELD_W;
    localparam int RAW  = PW + WIW;
    localparam int CAP  = (MAX_SLOTS > 255) ? 255 : MAX_SLOTS;
    localparam logic [SPP_W-1:0] CAP_V = SPP_W'(CAP);

    t_state             r_state, n_state;
    logic [OBJ_W-1:0]   r_obj;
    logic [SPP_W-1:0]   r_spp;
    logic [OFF_W-1:0]   r_soff;
    logic [OPG-1:0]     r_open, n_open;
    logic [FUNC_W-1:0]  r_func, n_func;
    logic [PW-1:0]      r_page, n_page;
    logic [WIW-1:0]     r_word, n_word;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [ST_W-1:0]    r_st_status, n_st_status;
    logic [ADDR_W-1:0]  r_st_addr, n_st_addr;
    logic               r_out_valid, n_out_valid;
    logic [ST_W-1:0]    r_out_status, n_out_status;
    logic [ADDR_W-1:0]  r_out_addr, n_out_addr;

    logic               accept;
    logic [SPP_W-1:0]   usable;
    logic               usable_nz;
    logic [PG_FIELD_W-1:0] addr_page;
    logic [OFF_W-1:0]   addr_off;
    logic               addr_bad;
    logic [PEW-1:0]     pg_ext;
    logic [OEW-1:0]     om1_ext;
    logic [OEW-1:0]     op_ext;
    logic [AEW-1:0]     p_ext;
    logic [ADDR_W-1:0]  alloc_addr;
    logic               word_last;
    logic               page_zero;
    logic               can_open;
    logic               can_open_next;
    logic [WORD_W-1:0]  free_mask;
    logic               scan_hit;
    logic [BIT_W-1:0]   hit_bit;
    logic               q_bad;

    logic               ram_wr_en;
    logic [RAW-1:0]     ram_wr_addr;
    logic [WORD_W-1:0]  ram_wr_data;
    logic               ram_rd_en;
    logic [RAW-1:0]     ram_rd_addr;
    logic [WORD_W-1:0]  ram_rd_data;

    t_md_req            md_req;
    logic [OPW-1:0]     md_a;
    logic               md_done;
    logic [ADDR_W-1:0]  md_product;
    logic [OPW-1:0]     md_quotient;

    psa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (1 << RAW)
    ) u_bitmap_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    psa_muldiv #(
        .OPW (OPW)
    ) u_muldiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (md_req),
        .i_a        (md_a),
        .i_b        (r_obj),
        .o_done     (md_done),
        .o_product  (md_product),
        .o_quotient (md_quotient)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj  <= OBJ_SIZE_RST;
            r_spp  <= SPP_RST;
            r_soff <= SOFF_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_OBJECT_SIZE:    r_obj  <= i_cfg_wr_data[OBJ_W-1:0];
                CFG_SLOTS_PER_PAGE: r_spp  <= i_cfg_wr_data[SPP_W-1:0];
                CFG_STORAGE_OFFSET: r_soff <= i_cfg_wr_data[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        accept        = i_in_valid && (r_state == S_IDLE);
        usable        = (r_spp > CAP_V) ? CAP_V : r_spp;
        usable_nz     = usable != '0;
        addr_page     = i_address[ADDR_W-1:PAGE_SHIFT];
        addr_off      = i_address[PAGE_SHIFT-1:0];
        addr_bad      = !(PCW'(addr_page) < PCW'(r_open)) || addr_off == '0
                        || addr_off < r_soff;
        pg_ext        = PEW'(addr_page);
        om1_ext       = OEW'(r_open - OPG'(1));
        op_ext        = OEW'(r_open);
        p_ext         = AEW'(r_page);
        alloc_addr    = {p_ext[PG_FIELD_W-1:0], {PAGE_SHIFT{1'b0}}}
                        + ADDR_W'(r_soff) + md_product;
        word_last     = r_word == WIW'(WPP - 1);
        page_zero     = r_page == '0;
        can_open      = r_open < OPG'(NUM_PAGES);
        can_open_next = (r_open + OPG'(1)) < OPG'(NUM_PAGES);
        q_bad         = md_quotient >= OPW'(usable);
    end

    // lowest free slot of the word just read
    always_comb begin
        scan_hit = 1'b0;
        hit_bit  = '0;
        for (int b = 0; b < WORD_W; b++) begin
            free_mask[b] = !ram_rd_data[b] && (CW'({r_word, BIT_W'(b)}) < CW'(usable));
        end
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (free_mask[b]) begin
                scan_hit = 1'b1;
                hit_bit  = BIT_W'(b);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_func == FN_ALLOC) begin
                        n_state = (r_open != '0) ? S_SCAN_RD : S_OPEN;
                    end else if (i_func == FN_FREE) begin
                        n_state = addr_bad ? S_OUT : S_CALC;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SCAN_RD: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                priority if (scan_hit) begin
                    n_state = S_CALC;
                end else if (!word_last || !page_zero) begin
                    n_state = S_SCAN_RD;
                end else if (can_open) begin
                    n_state = S_OPEN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OPEN: begin
                priority if (!word_last) begin
                    n_state = S_OPEN;
                end else if (usable_nz) begin
                    n_state = S_CALC;
                end else if (can_open_next) begin
                    n_state = S_OPEN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_CALC: begin
                if (md_done) begin
                    if (r_func == FN_FREE) begin
                        n_state = q_bad ? S_OUT : S_FREE_RD;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_FREE_RD: n_state = S_FREE_WR;
            S_FREE_WR: n_state = S_OUT;
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ram and shared unit controls
    always_comb begin
        o_in_stall  = r_state != S_IDLE;
        ram_wr_en   = 1'b0;
        ram_wr_addr = {r_page, r_word};
        ram_wr_data = '0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = {r_page, r_word};
        md_req      = '{start: 1'b0, op: MD_MUL};
        md_a        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_func == FN_FREE && !addr_bad) begin
                    md_req = '{start: 1'b1, op: MD_DIV};
                    md_a   = OPW'(addr_off - r_soff);
                end
            end
            S_SCAN_RD: ram_rd_en = 1'b1;
            S_SCAN_CHK: begin
                if (scan_hit) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data | (WORD_W'(1) << hit_bit);
                    md_req      = '{start: 1'b1, op: MD_MUL};
                    md_a        = OPW'({r_word, hit_bit});
                end
            end
            S_OPEN: begin
                // fresh page: clear the bitmap, slot 0 taken at once if usable
                ram_wr_en   = 1'b1;
                ram_wr_data = (r_word == '0 && usable_nz) ? WORD_W'(1) : '0;
                if (word_last && usable_nz) begin
                    md_req = '{start: 1'b1, op: MD_MUL};
                end
            end
            S_FREE_RD: ram_rd_en = 1'b1;
            S_FREE_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = ram_rd_data & ~(WORD_W'(1) << r_bit);
            end
            S_CALC, S_OUT: ;
            default: ;
        endcase
    end

    // datapath registers
    always_comb begin
        n_open       = r_open;
        n_func       = r_func;
        n_page       = r_page;
        n_word       = r_word;
        n_bit        = r_bit;
        n_st_status  = r_st_status;
        n_st_addr    = r_st_addr;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func      = i_func;
                    n_word      = '0;
                    n_st_status = ST_OK;
                    n_st_addr   = '0;
                    if (i_func == FN_ALLOC) begin
                        n_page = (r_open != '0) ? om1_ext[PW-1:0] : op_ext[PW-1:0];
                    end else if (i_func == FN_FREE) begin
                        n_page = pg_ext[PW-1:0];
                        if (addr_bad) begin
                            n_st_status = ST_BAD_FREE;
                        end
                    end else if (i_func == FN_RELEASE) begin
                        n_open = '0;
                    end
                end
            end
            S_SCAN_CHK: begin
                priority if (scan_hit) begin
                    n_word = r_word;
                end else if (!word_last) begin
                    n_word = r_word + WIW'(1);
                end else if (!page_zero) begin
                    n_page = r_page - PW'(1);
                    n_word = '0;
                end else if (can_open) begin
                    n_page = op_ext[PW-1:0];
                    n_word = '0;
                end else begin
                    n_st_status = ST_NO_PAGE;
                end
            end
            S_OPEN: begin
                if (!word_last) begin
                    n_word = r_word + WIW'(1);
                end else begin
                    n_open = r_open + OPG'(1);
                    if (!usable_nz) begin
                        if (can_open_next) begin
                            n_page = r_page + PW'(1);
                            n_word = '0;
                        end else begin
                            n_st_status = ST_NO_PAGE;
                        end
                    end
                end
            end
            S_CALC: begin
                if (md_done) begin
                    if (r_func == FN_FREE) begin
                        if (q_bad) begin
                            n_st_status = ST_BAD_FREE;
                        end else begin
                            n_word = md_quotient[SLW-1:BIT_W];
                            n_bit  = md_quotient[BIT_W-1:0];
                        end
                    end else begin
                        n_st_addr = alloc_addr;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_st_status;
                    n_out_addr   = r_st_addr;
                end
            end
            S_SCAN_RD, S_FREE_RD, S_FREE_WR: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_open      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_open      <= n_open;
            r_out_valid <= n_out_valid;
        end
        r_func       <= n_func;
        r_page       <= n_page;
        r_word       <= n_word;
        r_bit        <= n_bit;
        r_st_status  <= n_st_status;
        r_st_addr    <= n_st_addr;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_result_address = r_out_addr;

`ifndef NO_ASSERTIONS
    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= OPG'(NUM_PAGES))
        else $error("open page count beyond pool size");

    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_done |-> r_state == S_CALC)
        else $error("shared unit finished outside of calc state");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> o_result_address == '0)
        else $error("failed request carries a nonzero address");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("new request taken while one is in flight");
`endif

endmodule

// ===== sv/psa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/psa_muldiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_muldiv
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module psa_muldiv import psa_pkg::*; #(
    parameter int OPW = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_md_req           i_req,
    input  logic [OPW-1:0]    i_a,
    input  logic [OBJ_W-1:0]  i_b,
    output logic              o_done,
    output logic [ADDR_W-1:0] o_product,
    output logic [OPW-1:0]    o_quotient
);

    localparam int CNT_W = $clog2(OPW + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_md_op            r_op, n_op;
    logic [OPW-1:0]    r_a, n_a;
    logic [OBJ_W-1:0]  r_b, n_b;
    logic [ADDR_W-1:0] r_acc, n_acc;
    logic [OBJ_W-1:0]  r_rem, n_rem;

    logic [OBJ_W:0]    sh;
    logic [OBJ_W:0]    diff;
    logic              ge;
    logic [ADDR_W-1:0] addend;

    always_comb begin
        sh     = {r_rem, r_a[OPW-1]};
        ge     = sh >= {1'b0, r_b};
        diff   = sh - {1'b0, r_b};
        addend = r_a[OPW-1] ? ADDR_W'(r_b) : '0;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_op   = r_op;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_rem  = r_rem;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(OPW);
            n_op   = i_req.op;
            n_a    = i_a;
            // divide by zero object size behaves as divide by one
            n_b    = (i_req.op == MD_DIV && i_b == '0) ? OBJ_W'(1) : i_b;
            n_acc  = '0;
            n_rem  = '0;
        end else if (r_busy) begin
            n_cnt = r_cnt - CNT_W'(1);
            if (r_op == MD_MUL) begin
                n_acc = {r_acc[ADDR_W-2:0], 1'b0} + addend;
                n_a   = {r_a[OPW-2:0], 1'b0};
            end else begin
                n_rem = ge ? diff[OBJ_W-1:0] : sh[OBJ_W-1:0];
                n_a   = {r_a[OPW-2:0], ge};
            end
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_op  <= n_op;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_rem <= n_rem;
    end

    assign o_done     = r_done;
    assign o_product  = r_acc;
    assign o_quotient = r_a;

endmodule

// ===== tb/sv/paged_bitmap_slot_allocator_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_bitmap_slot_allocator_core_tb
// Self-checking bench for the paged bitmap slot allocator.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the page bitmaps, the open page count and
// the three registers. It works out the expected status and address for
// every accepted request and checks each result against the oldest one in
// order. A short directed run covers the corner cases, including zero object
// size, zero slots per page, bad frees and release. Random runs follow under
// several register settings, mostly allocations and frees of live objects.
// Sender and receiver idle at random, and one long receiver hold fills the
// block up.
// ----------------------------------------------------------------------------
module paged_bitmap_slot_allocator_core_tb;
    import psa_pkg::*;

    localparam int NUM_PAGES = 16;
    localparam int MAX_SLOTS = 256;
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam int MAX_PRINTED = 50;
    localparam int MAX_LIVE = 64;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] addr;
    } t_alloc_result;

    class alloc_scoreboard;
        t_alloc_result     outstanding[$];
        logic [ADDR_W-1:0] live_addrs[$];
        bit [MAX_SLOTS-1:0] used_map[NUM_PAGES];
        int                pages_open;
        logic [OBJ_W-1:0]  obj_size;
        logic [SPP_W-1:0]  slots_per_page;
        logic [OFF_W-1:0]  slot_base;
        int                errors;
        int                requests;
        int                results;
        int                granted;
        int                out_of_pages;
        int                rejected_frees;

        function new();
            for (int p = 0; p < NUM_PAGES; p++) begin
                used_map[p] = '0;
            end
            pages_open = 0;
            obj_size = OBJ_SIZE_RST;
            slots_per_page = SPP_RST;
            slot_base = SOFF_RST;
        endfunction

        function int pending();
            return outstanding.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_OBJECT_SIZE:    obj_size = val[OBJ_W-1:0];
                CFG_SLOTS_PER_PAGE: slots_per_page = val[SPP_W-1:0];
                CFG_STORAGE_OFFSET: slot_base = val[OFF_W-1:0];
                default: ;
            endcase
        endfunction

        function int usable_slots();
            return (slots_per_page > MAX_SLOTS) ? MAX_SLOTS : int'(slots_per_page);
        endfunction

        function int take_slot(int pg);
            for (int s = 0; s < usable_slots(); s++) begin
                if (!used_map[pg][s]) begin
                    used_map[pg][s] = 1'b1;
                    return s;
                end
            end
            return -1;
        endfunction

        function logic [ADDR_W-1:0] slot_address(int pg, int s);
            longint unsigned full;
            full = longint'(pg) * PAGE_BYTES + longint'(slot_base)
                   + longint'(s) * longint'(obj_size);
            return full[ADDR_W-1:0];
        endfunction

        function t_alloc_result predict_alloc();
            t_alloc_result r;
            int s;
            r.status = ST_OK;
            r.addr = '0;
            for (int pg = pages_open - 1; pg >= 0; pg--) begin
                s = take_slot(pg);
                if (s >= 0) begin
                    r.addr = slot_address(pg, s);
                    return r;
                end
            end
            while (pages_open < NUM_PAGES) begin
                used_map[pages_open] = '0;
                pages_open++;
                s = take_slot(pages_open - 1);
                if (s >= 0) begin
                    r.addr = slot_address(pages_open - 1, s);
                    return r;
                end
            end
            r.status = ST_NO_PAGE;
            return r;
        endfunction

        function logic [ST_W-1:0] predict_free(logic [ADDR_W-1:0] addr);
            int pg;
            int off;
            int divisor;
            int idx;
            pg = int'(addr) / PAGE_BYTES;
            off = int'(addr) % PAGE_BYTES;
            divisor = (obj_size == 0) ? 1 : int'(obj_size);
            if (pg >= pages_open || off == 0 || off < int'(slot_base)) begin
                return ST_BAD_FREE;
            end
            idx = (off - int'(slot_base)) / divisor;
            if (idx >= usable_slots()) begin
                return ST_BAD_FREE;
            end
            used_map[pg][idx] = 1'b0;
            return ST_OK;
        endfunction

        function void note_request(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] addr);
            t_alloc_result r;
            r.status = ST_OK;
            r.addr = '0;
            requests++;
            case (fn)
                FN_ALLOC: begin
                    r = predict_alloc();
                    if (r.status == ST_OK) begin
                        granted++;
                        live_addrs.push_back(r.addr);
                        if (live_addrs.size() > MAX_LIVE) begin
                            void'(live_addrs.pop_front());
                        end
                    end else begin
                        out_of_pages++;
                    end
                end
                FN_FREE: begin
                    r.status = predict_free(addr);
                    if (r.status != ST_OK) begin
                        rejected_frees++;
                    end
                end
                FN_RELEASE: begin
                    pages_open = 0;
                    live_addrs.delete();
                end
                default: ;
            endcase
            outstanding.push_back(r);
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTED) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
            errors++;
        endtask

        task check_result(logic [ST_W-1:0] st, logic [ADDR_W-1:0] addr);
            t_alloc_result want;
            results++;
            if (outstanding.size() == 0) begin
                report_mismatch($sformatf("result %0d unexpected: status %0d address 0x%0h",
                                          results, st, addr));
                return;
            end
            want = outstanding.pop_front();
            if (st !== want.status) begin
                report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                          results, st, want.status));
            end
            if (addr !== want.addr) begin
                report_mismatch($sformatf("result %0d address 0x%0h, expected 0x%0h",
                                          results, addr, want.addr));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [FUNC_W-1:0]     i_func;
    logic [ADDR_W-1:0]     i_address;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [ST_W-1:0]       o_status;
    logic [ADDR_W-1:0]     o_result_address;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data;

    alloc_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int settings_used;

    paged_bitmap_slot_allocator_core #(
        .NUM_PAGES(NUM_PAGES),
        .MAX_SLOTS(MAX_SLOTS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_address       (i_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_result_address(o_result_address),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // result side: random stall, long hold on request
    initial begin
        int hold_left;
        int holds_done;
        hold_left = 0;
        holds_done = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check_result(o_status, o_result_address);
            end
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    task automatic set_idle(input int mode);
        case (mode)
            0: begin
                send_idle_pct = 7;
                recv_idle_pct = 66;
            end
            1: begin
                send_idle_pct = 66;
                recv_idle_pct = 7;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= fn;
        i_address <= addr;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(fn, addr);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_setting(input logic [OBJ_W-1:0] obj, input logic [SPP_W-1:0] spp,
                                 input logic [OFF_W-1:0] base);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        write_reg(CFG_OBJECT_SIZE, obj);
        write_reg(CFG_SLOTS_PER_PAGE, CFG_DATA_W'(spp));
        write_reg(CFG_STORAGE_OFFSET, base);
        i_cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic random_setting();
        logic [OBJ_W-1:0] obj;
        logic [SPP_W-1:0] spp;
        logic [OFF_W-1:0] base;
        obj = ($urandom_range(0, 3) == 0) ? OBJ_W'($urandom_range(0, 2047))
                                          : OBJ_W'($urandom_range(1, 40) * 8);
        spp = ($urandom_range(0, 3) == 0) ? SPP_W'($urandom_range(0, 255))
                                          : SPP_W'($urandom_range(1, 20));
        base = ($urandom_range(0, 3) == 0) ? OFF_W'($urandom_range(0, 2047))
                                           : OFF_W'($urandom_range(24, 300));
        apply_setting(obj, spp, base);
    endtask

    // mostly allocations and frees of live objects, some noise
    task automatic run_traffic(input int count);
        int pick;
        int slack;
        logic [FUNC_W-1:0] fn;
        logic [ADDR_W-1:0] addr;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            addr = ADDR_W'($urandom_range(0, 32767));
            if (pick < 45) begin
                fn = FN_ALLOC;
            end else if (pick < 80 && sb.live_addrs.size() > 0) begin
                fn = FN_FREE;
                slack = (sb.obj_size > 1 && $urandom_range(0, 3) == 0) ?
                        int'(sb.obj_size) - 1 : 0;
                addr = sb.live_addrs[$urandom_range(0, sb.live_addrs.size() - 1)]
                       + ADDR_W'($urandom_range(0, slack));
            end else if (pick < 94) begin
                fn = FN_FREE;
            end else if (pick < 97) begin
                fn = FN_RELEASE;
            end else begin
                fn = FN_UNUSED;
            end
            send_request(fn, addr);
        end
    endtask

    initial begin
        sb = new();
        hold_requests = 0;
        settings_used = 1;
        set_idle(0);
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_func <= FN_ALLOC;
        i_address <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CFG_OBJECT_SIZE;
        i_cfg_wr_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: basic allocation, bad frees, double free, release
        send_request(FN_FREE, 15'd0);
        send_request(FN_ALLOC, 15'd0);
        send_request(FN_ALLOC, 15'h7fff);
        send_request(FN_ALLOC, 15'd0);
        send_request(FN_FREE, 15'd64);
        send_request(FN_FREE, 15'd64);
        send_request(FN_FREE, 15'd67);
        send_request(FN_ALLOC, 15'd0);
        send_request(FN_FREE, 15'd0);
        send_request(FN_FREE, 15'd55);
        send_request(FN_FREE, 15'd2040);
        send_request(FN_UNUSED, 15'h7fff);
        send_request(FN_FREE, 15'h7fff);
        send_request(FN_RELEASE, 15'h5555);
        send_request(FN_ALLOC, 15'h2aaa);

        // zero object size
        apply_setting(11'd0, 8'd3, 11'd24);
        send_request(FN_ALLOC, 15'd0);
        send_request(FN_ALLOC, 15'd0);
        send_request(FN_FREE, 15'd25);
        send_request(FN_FREE, 15'd24);

        // zero slots per page: pool runs dry at once
        apply_setting(11'd8, 8'd0, 11'd56);
        send_request(FN_ALLOC, 15'd0);
        send_request(FN_ALLOC, 15'd0);
        send_request(FN_FREE, 15'd56);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1:       apply_setting(11'd2047, 8'd255, 11'd2047);
                2:       apply_setting(11'd8, 8'd2, 11'd0);
                4:       apply_setting(11'd2016, 8'd248, 11'd24);
                default: random_setting();
            endcase
            set_idle(ph / 2);
            if (ph == 4) begin
                hold_requests++;
            end
            run_traffic(105);
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        end
        $display("Checked %0d requests under %0d register settings, %0d results seen.",
                 sb.requests, settings_used, sb.results);
        $display("Allocations granted %0d, out of pages %0d, frees rejected %0d.",
                 sb.granted, sb.out_of_pages, sb.rejected_frees);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/psa_pkg.sv
sv/psa_ram.sv
sv/psa_muldiv.sv
sv/paged_bitmap_slot_allocator_core.sv
tb/sv/paged_bitmap_slot_allocator_core_tb.sv
